[hdl/aflm_pkg.sv]
// Shared types and constants of the audio frame level meter.
`timescale 1ns / 1ps
package aflm_pkg;

  // Register indexes of the configuration port (byte address = 4 * index)
  localparam logic [1:0] REG_CHANNELS = 2'd0;
  localparam logic [1:0] REG_FRAME    = 2'd1;
  localparam logic [1:0] REG_SAT      = 2'd2;
  localparam logic [1:0] REG_QUIET    = 2'd3;

  localparam logic [1:0]  CHANNELS_RESET = 2'd1;
  localparam logic [9:0]  FRAME_RESET    = 10'd480;
  localparam logic [15:0] SAT_RESET      = 16'd32760;
  localparam logic [15:0] QUIET_RESET    = 16'd8;

  localparam int PERMILLE = 1000;

  // Division jobs run at frame end, one after another per channel
  typedef enum logic [2:0] {
    OP_ABS,
    OP_SQ,
    OP_MEAN,
    OP_SAT,
    OP_ZERO
  } aflm_op_e;

  typedef struct packed {
    logic     acc;        // add accepted sample into channel ch
    logic     clear;      // zero all accumulators
    logic     div_load;   // start a division job of kind op
    aflm_op_e op;
    logic     sqrt_load;  // start root of the mean square
    logic     out_load;   // capture result payload
    logic     ch;
    logic     last;
  } aflm_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic sqrt_busy;
  } aflm_status_t;

endpackage

[hdl/aflm_ctrl.sv]
// Controller: sample sequencing, frame close and end-of-frame job sequencing.
`timescale 1ns / 1ps
module aflm_ctrl import aflm_pkg::*; #(
  parameter int MAX_FRAME    = 512,
  parameter int MAX_CHANNELS = 2,
  parameter int CW           = $clog2(MAX_FRAME + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [1:0]    channel_count_i,
  input  logic [9:0]    frame_length_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output aflm_cmd_t     cmd_o,
  input  aflm_status_t  status_i,
  output logic [CW-1:0] frame_count_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DLOAD = 3'd1;
  localparam logic [2:0] S_DWAIT = 3'd2;
  localparam logic [2:0] S_SLOAD = 3'd3;
  localparam logic [2:0] S_SWAIT = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] pos_q, pos_d;
  logic          cur_q, cur_d;
  logic          fch_q, fch_d;
  aflm_op_e      op_q, op_d;

  logic [1:0]    chans;
  logic [CW-1:0] eff_frame;
  logic          ch;
  logic          group_end;
  logic [CW-1:0] pos_inc;
  logic          fch_last;

  always_comb begin
    if (channel_count_i == 2'd0) begin
      chans = 2'd1;
    end else if (32'(channel_count_i) > 32'(MAX_CHANNELS)) begin
      chans = 2'(MAX_CHANNELS);
    end else begin
      chans = channel_count_i;
    end
    if (frame_length_i == 10'd0) begin
      eff_frame = CW'(1);
    end else if (32'(frame_length_i) > 32'(MAX_FRAME)) begin
      eff_frame = CW'(MAX_FRAME);
    end else begin
      eff_frame = CW'(frame_length_i);
    end
  end

  // a channel index beyond the count folds onto the last channel
  assign ch        = (2'(cur_q) >= chans) ? 1'((chans - 2'd1)) : cur_q;
  assign group_end = (2'(ch) + 2'd1) >= chans;
  assign pos_inc   = pos_q + CW'(1);
  assign fch_last  = (2'(fch_q) + 2'd1) >= chans;

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = (state_q == S_OUT);
  assign frame_count_o = pos_q;

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    cur_d   = cur_q;
    fch_d   = fch_q;
    op_d    = op_q;
    cmd_o   = '0;
    cmd_o.op   = op_q;
    cmd_o.ch   = fch_q;
    cmd_o.last = fch_last;
    case (state_q)
      S_IDLE: begin
        cmd_o.ch = ch;
        if (in_valid_i) begin
          cmd_o.acc = 1'b1;
          if (!group_end) begin
            cur_d = ~ch;
          end else begin
            cur_d = 1'b0;
            pos_d = pos_inc;
            if (pos_inc >= eff_frame) begin
              fch_d   = 1'b0;
              op_d    = OP_ABS;
              state_d = S_DLOAD;
            end
          end
        end
      end
      S_DLOAD: begin
        cmd_o.div_load = 1'b1;
        state_d        = S_DWAIT;
      end
      S_DWAIT: begin
        if (!status_i.div_busy) begin
          state_d = S_DLOAD;
          case (op_q)
            OP_ABS:  op_d = OP_SQ;
            OP_SQ:   op_d = OP_MEAN;
            OP_MEAN: op_d = OP_SAT;
            OP_SAT:  op_d = OP_ZERO;
            default: state_d = S_SLOAD;
          endcase
        end
      end
      S_SLOAD: begin
        cmd_o.sqrt_load = 1'b1;
        state_d         = S_SWAIT;
      end
      S_SWAIT: begin
        if (!status_i.sqrt_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready_i) begin
          if (fch_last) begin
            cmd_o.clear = 1'b1;
            pos_d       = '0;
            state_d     = S_IDLE;
          end else begin
            fch_d   = ~fch_q;
            op_d    = OP_ABS;
            state_d = S_DLOAD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pos_q   <= '0;
      cur_q   <= 1'b0;
      fch_q   <= 1'b0;
      op_q    <= OP_ABS;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      cur_q   <= cur_d;
      fch_q   <= fch_d;
      op_q    <= op_d;
    end
  end

endmodule

[hdl/aflm_dp.sv]
// Datapath: per-channel accumulators, serial divider, serial square root, result registers.
`timescale 1ns / 1ps
module aflm_dp import aflm_pkg::*; #(
  parameter int MAX_FRAME    = 512,
  parameter int MAX_CHANNELS = 2,
  parameter int CW           = $clog2(MAX_FRAME + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [15:0]        saturation_level_i,
  input  logic [15:0]        quiet_level_i,
  input  logic signed [15:0] sample_i,
  input  aflm_cmd_t          cmd_i,
  output aflm_status_t       status_o,
  input  logic [CW-1:0]      frame_count_i,
  output logic               channel_o,
  output logic [15:0]        avg_abs_o,
  output logic [15:0]        rms_o,
  output logic signed [15:0] mean_o,
  output logic [15:0]        peak_o,
  output logic [9:0]         sat_permille_o,
  output logic [9:0]         zero_permille_o,
  output logic               last_o
);

  localparam int AW  = 16 + CW;
  localparam int SQW = 31 + CW;
  localparam int SW  = 17 + CW;
  localparam int DW  = SQW;
  localparam int DCW = $clog2(DW + 1);

  logic [AW-1:0]         abs_sum_q    [MAX_CHANNELS];
  logic [SQW-1:0]        square_sum_q [MAX_CHANNELS];
  logic signed [SW-1:0]  signed_sum_q [MAX_CHANNELS];
  logic [15:0]           peak_q       [MAX_CHANNELS];
  logic [CW-1:0]         sat_cnt_q    [MAX_CHANNELS];
  logic [CW-1:0]         quiet_cnt_q  [MAX_CHANNELS];

  logic [15:0] mag;
  logic [31:0] mag_sq;

  assign mag    = sample_i[15] ? (16'd0 - sample_i) : sample_i;
  assign mag_sq = mag * mag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < MAX_CHANNELS; c++) begin
        abs_sum_q[c]    <= '0;
        square_sum_q[c] <= '0;
        signed_sum_q[c] <= '0;
        peak_q[c]       <= '0;
        sat_cnt_q[c]    <= '0;
        quiet_cnt_q[c]  <= '0;
      end
    end else begin
      for (int c = 0; c < MAX_CHANNELS; c++) begin
        if (cmd_i.clear) begin
          abs_sum_q[c]    <= '0;
          square_sum_q[c] <= '0;
          signed_sum_q[c] <= '0;
          peak_q[c]       <= '0;
          sat_cnt_q[c]    <= '0;
          quiet_cnt_q[c]  <= '0;
        end else if (cmd_i.acc && (c == int'(cmd_i.ch))) begin
          abs_sum_q[c]    <= abs_sum_q[c] + AW'(mag);
          square_sum_q[c] <= square_sum_q[c] + SQW'(mag_sq);
          signed_sum_q[c] <= signed_sum_q[c] + SW'(sample_i);
          if (mag > peak_q[c]) peak_q[c] <= mag;
          if (mag >= saturation_level_i) sat_cnt_q[c] <= sat_cnt_q[c] + CW'(1);
          if (mag <= quiet_level_i) quiet_cnt_q[c] <= quiet_cnt_q[c] + CW'(1);
        end
      end
    end
  end

  // read the finishing channel
  logic [AW-1:0]        sel_abs;
  logic [SQW-1:0]       sel_sq;
  logic signed [SW-1:0] sel_ss;
  logic [15:0]          sel_peak;
  logic [CW-1:0]        sel_sat;
  logic [CW-1:0]        sel_quiet;

  always_comb begin
    sel_abs   = abs_sum_q[0];
    sel_sq    = square_sum_q[0];
    sel_ss    = signed_sum_q[0];
    sel_peak  = peak_q[0];
    sel_sat   = sat_cnt_q[0];
    sel_quiet = quiet_cnt_q[0];
    for (int c = 0; c < MAX_CHANNELS; c++) begin
      if (c == int'(cmd_i.ch)) begin
        sel_abs   = abs_sum_q[c];
        sel_sq    = square_sum_q[c];
        sel_ss    = signed_sum_q[c];
        sel_peak  = peak_q[c];
        sel_sat   = sat_cnt_q[c];
        sel_quiet = quiet_cnt_q[c];
      end
    end
  end

  // restoring divider, one quotient bit per cycle
  logic [DW-1:0]  dividend;
  logic [DW-1:0]  quo_q;
  logic [CW-1:0]  rem_q;
  logic [DCW-1:0] dcnt_q;
  logic           dbusy_q;
  logic           neg_q;
  aflm_op_e       dop_q;
  logic [CW:0]    rem_sh;
  logic           ge;
  logic [CW:0]    rem_n;
  logic [DW-1:0]  quo_n;
  logic [SW-1:0]  ss_mag;

  assign ss_mag = sel_ss[SW-1] ? SW'(-sel_ss) : SW'(sel_ss);

  always_comb begin
    case (cmd_i.op)
      OP_ABS:  dividend = DW'(sel_abs);
      OP_SQ:   dividend = DW'(sel_sq);
      OP_MEAN: dividend = DW'(ss_mag);
      OP_SAT:  dividend = DW'(sel_sat) * DW'(PERMILLE);
      default: dividend = DW'(sel_quiet) * DW'(PERMILLE);
    endcase
  end

  assign rem_sh = {rem_q, quo_q[DW-1]};
  assign ge     = rem_sh >= {1'b0, frame_count_i};
  assign rem_n  = ge ? (rem_sh - {1'b0, frame_count_i}) : rem_sh;
  assign quo_n  = {quo_q[DW-2:0], ge};

  logic [15:0]   avg_q;
  logic [30:0]   sqmean_q;
  logic [15:0]   mean_q;
  logic [9:0]    satp_q;
  logic [9:0]    zerop_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbusy_q <= 1'b0;
      dcnt_q  <= '0;
    end else if (cmd_i.div_load) begin
      dbusy_q <= 1'b1;
      dcnt_q  <= DCW'(DW);
    end else if (dbusy_q) begin
      dcnt_q <= dcnt_q - DCW'(1);
      if (dcnt_q == DCW'(1)) dbusy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      quo_q <= dividend;
      rem_q <= '0;
      dop_q <= cmd_i.op;
      neg_q <= sel_ss[SW-1];
    end else if (dbusy_q) begin
      quo_q <= quo_n;
      rem_q <= rem_n[CW-1:0];
      if (dcnt_q == DCW'(1)) begin
        case (dop_q)
          OP_ABS:  avg_q    <= quo_n[15:0];
          OP_SQ:   sqmean_q <= quo_n[30:0];
          OP_MEAN: mean_q   <= neg_q ? (16'd0 - quo_n[15:0]) : quo_n[15:0];
          OP_SAT:  satp_q   <= quo_n[9:0];
          default: zerop_q  <= quo_n[9:0];
        endcase
      end
    end
  end

  // digit-by-digit square root, one root bit per cycle
  logic [31:0] sv_q;
  logic [17:0] srem_q;
  logic [15:0] sroot_q;
  logic [4:0]  scnt_q;
  logic        sbusy_q;
  logic [19:0] srem_sh;
  logic [19:0] strial;
  logic        sge;
  logic [19:0] srem_n;

  assign srem_sh = {srem_q, sv_q[31:30]};
  assign strial  = {2'b00, sroot_q, 2'b01};
  assign sge     = srem_sh >= strial;
  assign srem_n  = sge ? (srem_sh - strial) : srem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sbusy_q <= 1'b0;
      scnt_q  <= '0;
    end else if (cmd_i.sqrt_load) begin
      sbusy_q <= 1'b1;
      scnt_q  <= 5'd16;
    end else if (sbusy_q) begin
      scnt_q <= scnt_q - 5'd1;
      if (scnt_q == 5'd1) sbusy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_load) begin
      sv_q    <= {1'b0, sqmean_q};
      srem_q  <= '0;
      sroot_q <= '0;
    end else if (sbusy_q) begin
      sv_q    <= {sv_q[29:0], 2'b00};
      srem_q  <= srem_n[17:0];
      sroot_q <= {sroot_q[14:0], sge};
    end
  end

  assign status_o.div_busy  = dbusy_q;
  assign status_o.sqrt_busy = sbusy_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      channel_o       <= cmd_i.ch;
      avg_abs_o       <= avg_q;
      rms_o           <= sroot_q;
      mean_o          <= mean_q;
      peak_o          <= sel_peak;
      sat_permille_o  <= satp_q;
      zero_permille_o <= zerop_q;
      last_o          <= cmd_i.last;
    end
  end

endmodule

[hdl/audio_frame_level_meter.sv]
// Top level of the audio frame level meter: configuration registers, controller, datapath.
`timescale 1ns / 1ps
// Frame level meter for one or two interleaved channels of signed 16-bit
// audio. Each accepted sample transfer is folded into its channel's
// accumulators; the input is ready again in the next cycle.
// When a sample group completes a frame, the block stops taking samples
// and, per channel, runs five serial divisions (mean abs, mean square,
// mean, saturation and zero permille) on a shared restoring divider,
// one quotient bit per cycle, then a serial square root. The divider is
// DW = 31 + clog2(MAX_FRAME+1) bits wide (41 at the default). Results
// come out in channel order, last set on the final one; the accumulators
// clear on its transfer. Registers on the APB port at 4*i: channel count,
// frame length, saturation level, quiet level; write only while idle.
module audio_frame_level_meter import aflm_pkg::*; #(
  parameter int MAX_FRAME    = 512,
  parameter int MAX_CHANNELS = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] sample_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               channel_o,
  output logic [15:0]        avg_abs_o,
  output logic [15:0]        rms_o,
  output logic signed [15:0] mean_o,
  output logic [15:0]        peak_o,
  output logic [9:0]         sat_permille_o,
  output logic [9:0]         zero_permille_o,
  output logic               last_o
);

  localparam int CW = $clog2(MAX_FRAME + 1);

  logic [1:0]  chan_q;
  logic [9:0]  frame_q;
  logic [15:0] sat_q;
  logic [15:0] quiet_q;
  logic        wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q  <= CHANNELS_RESET;
      frame_q <= FRAME_RESET;
      sat_q   <= SAT_RESET;
      quiet_q <= QUIET_RESET;
    end else if (wr) begin
      case (paddr[3:2])
        REG_CHANNELS: chan_q  <= pwdata[1:0];
        REG_FRAME:    frame_q <= pwdata[9:0];
        REG_SAT:      sat_q   <= pwdata[15:0];
        REG_QUIET:    quiet_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_CHANNELS: prdata = 32'(chan_q);
      REG_FRAME:    prdata = 32'(frame_q);
      REG_SAT:      prdata = 32'(sat_q);
      REG_QUIET:    prdata = 32'(quiet_q);
      default:      prdata = '0;
    endcase
  end

  aflm_cmd_t     cmd;
  aflm_status_t  status;
  logic [CW-1:0] frame_count;

  aflm_ctrl #(
    .MAX_FRAME    (MAX_FRAME),
    .MAX_CHANNELS (MAX_CHANNELS),
    .CW           (CW)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .channel_count_i (chan_q),
    .frame_length_i  (frame_q),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .cmd_o           (cmd),
    .status_i        (status),
    .frame_count_o   (frame_count)
  );

  aflm_dp #(
    .MAX_FRAME    (MAX_FRAME),
    .MAX_CHANNELS (MAX_CHANNELS),
    .CW           (CW)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .saturation_level_i (sat_q),
    .quiet_level_i      (quiet_q),
    .sample_i           (sample_i),
    .cmd_i              (cmd),
    .status_o           (status),
    .frame_count_i      (frame_count),
    .channel_o          (channel_o),
    .avg_abs_o          (avg_abs_o),
    .rms_o              (rms_o),
    .mean_o             (mean_o),
    .peak_o             (peak_o),
    .sat_permille_o     (sat_permille_o),
    .zero_permille_o    (zero_permille_o),
    .last_o             (last_o)
  );

endmodule

[test/testbench.sv]
// Self-checking testbench for the audio frame level meter.
`timescale 1ns / 1ps
module testbench;
  import aflm_pkg::*;

  localparam int CLOCK_LIMIT = 5000000;
  localparam int SETTLE      = 20;    // cycles after the last result before a register write
  localparam int LONG_HOLD   = 2000;  // receiver hold-off for the back-pressure phase

  typedef struct packed {
    logic              channel;
    logic [15:0]       avg_abs;
    logic [15:0]       rms;
    logic signed [15:0] mean;
    logic [15:0]       peak;
    logic [9:0]        sat_permille;
    logic [9:0]        zero_permille;
    logic              last;
  } level_stats_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               psel, penable, pwrite;
  logic [3:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid_i;
  logic               in_ready_o;
  logic signed [15:0] sample_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               channel_o;
  logic [15:0]        avg_abs_o, rms_o, peak_o;
  logic signed [15:0] mean_o;
  logic [9:0]         sat_permille_o, zero_permille_o;
  logic               last_o;

  audio_frame_level_meter dut (.*);

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Samples waiting for the driver, and per-channel statistics expected from the block
  logic [15:0]  sample_backlog[$];
  level_stats_t expected_stats[$];

  int unsigned snd_idle_pct;   // chance per cycle that the sender offers nothing
  int unsigned rcv_stall_pct;  // chance per cycle that the receiver drops ready
  int unsigned mismatches;
  int unsigned clock_count;
  int unsigned hold_left;
  logic        hold_kick;

  // Shadow copies of the registers
  logic [1:0]  cfg_channels;
  logic [9:0]  cfg_frame;
  logic [15:0] cfg_sat, cfg_quiet;

  // Shadow accumulators
  longint unsigned abs_acc[2], sq_acc[2];
  longint          sum_acc[2];
  int unsigned     peak_acc[2], sat_cnt[2], quiet_cnt[2];
  int unsigned     group_count;  // completed sample groups in this frame
  int unsigned     next_chan;

  // Floor square root, one bit at a time from the top
  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // Fold one accepted sample into the shadow state; emit statistics at frame end
  function automatic void fold_sample(logic signed [15:0] s);
    int          sv;
    int unsigned mag, chans, ch, frame_n;
    level_stats_t st;
    longint      avg_signed;
    sv = s;
    mag = (sv < 0) ? -sv : sv;
    chans = (cfg_channels == 0) ? 1 : ((cfg_channels > 2) ? 2 : cfg_channels);
    ch = (next_chan >= chans) ? chans - 1 : next_chan;  // count lowered mid-group
    abs_acc[ch] += mag;
    sq_acc[ch]  += longint'(mag) * mag;
    sum_acc[ch] += sv;
    if (mag > peak_acc[ch]) peak_acc[ch] = mag;
    if (mag >= cfg_sat) sat_cnt[ch]++;
    if (mag <= cfg_quiet) quiet_cnt[ch]++;
    if (ch + 1 < chans) begin
      next_chan = ch + 1;
      return;
    end
    next_chan = 0;
    group_count++;
    frame_n = (cfg_frame == 0) ? 1 : ((cfg_frame > 512) ? 512 : cfg_frame);
    if (group_count < frame_n) return;
    // divisor is the real group count, which can exceed a lowered frame length
    for (int c = 0; c < chans; c++) begin
      avg_signed       = sum_acc[c] / longint'(group_count);  // truncates toward zero
      st.channel       = c[0];
      st.avg_abs       = 16'(abs_acc[c] / group_count);
      st.rms           = 16'(floor_root(sq_acc[c] / group_count));
      st.mean          = 16'(avg_signed);
      st.peak          = 16'(peak_acc[c]);
      st.sat_permille  = 10'((longint'(sat_cnt[c]) * PERMILLE) / group_count);
      st.zero_permille = 10'((longint'(quiet_cnt[c]) * PERMILLE) / group_count);
      st.last          = (c + 1 == chans);
      expected_stats.push_back(st);
    end
    for (int c = 0; c < 2; c++) begin
      abs_acc[c] = 0; sq_acc[c] = 0; sum_acc[c] = 0;
      peak_acc[c] = 0; sat_cnt[c] = 0; quiet_cnt[c] = 0;
    end
    group_count = 0;
  endfunction

  // Sample source: a quarter from the corner values, the rest uniform
  function automatic logic [15:0] pick_sample();
    logic [15:0] corners[10];
    corners = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001,
                16'h0008, 16'hFFF8, 16'h7FF8, 16'h8008, 16'h0009};
    if ($urandom_range(3) == 0) return corners[$urandom_range(9)];
    return 16'($urandom);
  endfunction

  // Sender: holds valid and payload until the transfer, then maybe idles
  always @(posedge clk_i) begin
    logic took;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      took = in_valid_i && in_ready_o;
      if (took) begin
        fold_sample(sample_i);
        void'(sample_backlog.pop_front());
      end
      if (in_valid_i && !took) begin
        // keep offering the same sample
      end else if (sample_backlog.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
        in_valid_i <= 1'b1;
        sample_i   <= sample_backlog[0];
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted here so the sender keeps running meanwhile
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_kick) begin
      hold_left <= LONG_HOLD;
    end
  end

  // Receiver: checks each result transfer against the oldest expectation
  always @(posedge clk_i) begin
    level_stats_t got, want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got = '{channel_o, avg_abs_o, rms_o, mean_o, peak_o,
                sat_permille_o, zero_permille_o, last_o};
        if (expected_stats.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: ch %0d avg %0d rms %0d mean %0d peak %0d sat %0d zero %0d last %0d",
                     got.channel, got.avg_abs, got.rms, got.mean, got.peak,
                     got.sat_permille, got.zero_permille, got.last);
        end else begin
          want = expected_stats.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result mismatch at %0t", $realtime);
              $display("  expected: ch %0d avg %0d rms %0d mean %0d peak %0d sat %0d zero %0d last %0d",
                       want.channel, want.avg_abs, want.rms, want.mean, want.peak,
                       want.sat_permille, want.zero_permille, want.last);
              $display("  actual:   ch %0d avg %0d rms %0d mean %0d peak %0d sat %0d zero %0d last %0d",
                       got.channel, got.avg_abs, got.rms, got.mean, got.peak,
                       got.sat_permille, got.zero_permille, got.last);
            end
          end
        end
      end
    end
    out_ready_i <= (hold_left == 0) && ($urandom_range(99) >= rcv_stall_pct);
  end

  // Watchdog
  always @(posedge clk_i) begin
    clock_count <= clock_count + 1;
    if (clock_count > CLOCK_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // APB write: setup cycle, then access cycle; pready is tied high
  task automatic reg_write(logic [1:0] idx, logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_CHANNELS: cfg_channels = value[1:0];
      REG_FRAME:    cfg_frame    = value[9:0];
      REG_SAT:      cfg_sat      = value[15:0];
      default:      cfg_quiet    = value[15:0];
    endcase
  endtask

  // Block until every sample is taken and every result checked, then let it settle
  task automatic drain();
    while (sample_backlog.size() > 0 || expected_stats.size() > 0 || in_valid_i)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic configure(int ch, int frame, int sat, int quiet);
    reg_write(REG_CHANNELS, ch);
    reg_write(REG_FRAME, frame);
    reg_write(REG_SAT, sat);
    reg_write(REG_QUIET, quiet);
  endtask

  task automatic queue_random(int count);
    repeat (count) sample_backlog.push_back(pick_sample());
  endtask

  initial begin
    logic [15:0] directed[$];
    int          pick;
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid_i = 1'b0; sample_i = '0; out_ready_i = 1'b0;
    hold_kick = 1'b0; hold_left = 0; clock_count = 0; mismatches = 0;
    snd_idle_pct = 0; rcv_stall_pct = 0;
    cfg_channels = CHANNELS_RESET; cfg_frame = FRAME_RESET;
    cfg_sat = SAT_RESET; cfg_quiet = QUIET_RESET;
    for (int c = 0; c < 2; c++) begin
      abs_acc[c] = 0; sq_acc[c] = 0; sum_acc[c] = 0;
      peak_acc[c] = 0; sat_cnt[c] = 0; quiet_cnt[c] = 0;
    end
    group_count = 0; next_chan = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: two channels, four groups per frame, default thresholds
    configure(2, 4, 32760, 8);
    directed = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h0008,
                 16'hFFF8, 16'h0009, 16'h7FF8, 16'h8008, 16'h7FF7, 16'hFFF7,
                 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF};
    foreach (directed[i]) sample_backlog.push_back(directed[i]);
    drain();

    // Every sample closes a frame; everything is quiet and saturated.
    // The receiver holds off long enough that the input backs up.
    configure(1, 1, 0, 32768);
    hold_kick <= 1'b1;
    @(posedge clk_i);
    hold_kick <= 1'b0;
    queue_random(20);
    drain();

    // Out-of-range codes: three channels, then zero channels with frame zero and thresholds above full scale
    snd_idle_pct = 58;
    configure(3, 3, 32768, 0);
    queue_random(30);
    drain();
    rcv_stall_pct = 58; snd_idle_pct = 0;
    configure(0, 0, 65535, 65535);
    queue_random(30);
    drain();

    // Longest frame; length above the limit clamps to it
    rcv_stall_pct = 6; snd_idle_pct = 6;
    configure(1, 1023, 32760, 8);
    queue_random(512);
    drain();

    // Random settings with short frames; partial frames carry across phases
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin snd_idle_pct = 58; rcv_stall_pct = 0;  end
        2: begin snd_idle_pct = 0;  rcv_stall_pct = 58; end
        default: begin snd_idle_pct = 6; rcv_stall_pct = 6; end
      endcase
      pick = $urandom_range(3);
      configure($urandom_range(3), $urandom_range(1, 16),
                (pick == 0) ? $urandom_range(65535) : $urandom_range(32700, 32768),
                (pick == 1) ? $urandom_range(65535) : $urandom_range(0, 64));
      queue_random(100);
      drain();
    end

    repeat (50) @(posedge clk_i);
    if (mismatches == 0 && expected_stats.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
